// ===== rtl/mtdu_pkg.sv =====
// ---------------------------------------------------------------------------
// mtdu_pkg
// shared types, constants and the tempering function of the mersenne twister draw unit
// ---------------------------------------------------------------------------
package mtdu_pkg;

  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned AW = 10;
  localparam logic [31:0] MATRIX_A = 32'h9908b0df;
  localparam logic [31:0] INIT_MUL = 32'd1812433253;
  localparam logic [31:0] SEED_RESET = 32'd5489;
  localparam logic [30:0] MASK31 = 31'h7fffffff;

  typedef enum logic [1:0] {
    OP_DRAW31  = 2'd0,
    OP_DRAW62  = 2'd1,
    OP_BOUNDED = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  draws;
    logic        is_mod;
    logic [31:0] bound;
  } req_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== rtl/mersenne_twister_draw_unit.sv =====
// a 31-bit draw reads one state word, a 62-bit draw two; a bounded draw reads one word
// and then runs a 32-step divider; a request with nothing to draw goes straight to the output
// one request is served at a time; a 62-bit request takes two draws
// every 624 draws a twist pass over the state ram runs before the next draw
// reset and seed writes run a seeding pass, during which no request is taken
// ---------------------------------------------------------------------------
// mersenne_twister_draw_unit
// mt19937 draw unit with apb seed register
// ---------------------------------------------------------------------------
module mersenne_twister_draw_unit
  import mtdu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] bound_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [61:0] value_o
);
  logic [31:0] seed_reg_q;
  logic        seed_we;
  logic        rv, take;
  req_t        rq;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata  = (paddr == 2'd0) ? seed_reg_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_reg_q <= SEED_RESET;
    else if (seed_we) seed_reg_q <= pwdata;
  end

  mtdu_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .opcode_i, .bound_i,
    .req_valid_o(rv), .req_o(rq), .req_take_i(take)
  );

  mtdu_back u_back (
    .clk_i, .rst_ni, .seed_we_i(seed_we), .seed_i(pwdata),
    .req_valid_i(rv), .req_i(rq), .req_take_o(take),
    .valid_o, .stall_i, .value_o
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_o)) else $error("result dropped");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> rv) else $error("take from empty queue");
`endif
endmodule

// ===== rtl/mtdu_ram.sv =====
// ---------------------------------------------------------------------------
// mtdu_ram
// generic single write port, single registered read port ram
// ---------------------------------------------------------------------------
module mtdu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/mtdu_front.sv =====
// ---------------------------------------------------------------------------
// mtdu_front
// accepts requests, classifies them and holds them in a two-entry queue
// ---------------------------------------------------------------------------
module mtdu_front
  import mtdu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] bound_i,
  output logic        req_valid_o,
  output req_t        req_o,
  input  logic        req_take_i
);
  req_t       q_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  req_t       cls;
  logic       push, pop;

  always_comb begin
    cls.bound  = bound_i;
    cls.is_mod = 1'b0;
    cls.draws  = 2'd0;
    unique case (op_e'(opcode_i))
      OP_DRAW31:  cls.draws = 2'd1;
      OP_DRAW62:  cls.draws = 2'd2;
      OP_BOUNDED: begin
        cls.is_mod = 1'b1;
        cls.draws  = (bound_i != 32'd0) ? 2'd1 : 2'd0;
      end
      default:    cls.draws = 2'd0;
    endcase
  end

  assign stall_o     = cnt_q[1];
  assign push        = valid_i && !stall_o;
  assign req_valid_o = cnt_q != 2'd0;
  assign pop         = req_valid_o && req_take_i;
  assign req_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/mtdu_div.sv =====
// ---------------------------------------------------------------------------
// mtdu_div
// radix-2 restoring remainder unit, one bit per cycle
// ---------------------------------------------------------------------------
module mtdu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  logic [31:0] num_q, den_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] sh, diff;

  assign sh     = {rem_q, num_q[31]};
  assign diff   = sh - {1'b0, den_q};
  assign rem_o  = rem_q;
  assign done_o = busy_q && (cnt_q == 6'd32);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != 6'd32) begin
      num_q <= num_q << 1;
      rem_q <= diff[32] ? sh[31:0] : diff[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end
endmodule

// ===== rtl/mtdu_back.sv =====
// ---------------------------------------------------------------------------
// mtdu_back
// state memory sequencer: seeding, twist pass, draws and remainder
// ---------------------------------------------------------------------------
module mtdu_back
  import mtdu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        req_valid_i,
  input  req_t        req_i,
  output logic        req_take_o,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [61:0] value_o
);
  typedef enum logic [3:0] {
    S_SEED, S_SEEDW, S_IDLE, S_TW0, S_TW1, S_TW2, S_TW3,
    S_RD, S_RDW, S_RDD, S_DIV, S_OUT
  } st_e;

  st_e         st_q, st_d;
  logic [AW-1:0] idx_q, idx_d, pos_q, pos_d;
  logic [31:0] prev_q, prev_d, a_q, a_d, b_q, b_d, seed_q;
  logic        mul_q, mul_d;
  logic [31:0] mulp_q;
  logic [1:0]  left_q, left_d;
  logic        second_q, second_d, ismod_q, ismod_d;
  logic [31:0] bound_q, bound_d;
  logic [30:0] lo_q, lo_d;
  logic [61:0] val_q, val_d;
  logic        pend_q;
  logic [31:0] wi_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          dstart, ddone;
  logic [31:0]   drem, tw, y;

  mtdu_ram #(.Width(32), .Depth(N)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mtdu_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(tw), .den_i(bound_q),
    .done_o(ddone), .rem_o(drem)
  );

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input int unsigned k);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(k);
    return (s >= (AW+1)'(N)) ? AW'(s - (AW+1)'(N)) : s[AW-1:0];
  endfunction

  assign tw = temper(rdata);
  assign y  = (a_q & 32'h80000000) | (b_q & 32'h7fffffff);

  always_ff @(posedge clk_i) begin
    mulp_q <= INIT_MUL * (prev_q ^ (prev_q >> 30));
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; pos_d = pos_q; prev_d = prev_q;
    a_d = a_q; b_d = b_q; mul_d = 1'b0; left_d = left_q;
    second_d = second_q; ismod_d = ismod_q; bound_d = bound_q;
    lo_d = lo_q; val_d = val_q;
    we = 1'b0; waddr = idx_q; wdata = '0; raddr = idx_q;
    dstart = 1'b0; req_take_o = 1'b0;
    unique case (st_q)
      // word 0 is the seed; then one multiply then write per word
      S_SEED: begin
        we = 1'b1; waddr = '0; wdata = seed_q;
        prev_d = seed_q; idx_d = AW'(1); st_d = S_SEEDW;
      end
      S_SEEDW: begin
        if (!mul_q) begin
          mul_d = 1'b1;
        end else begin
          we = 1'b1; wdata = mulp_q + 32'(idx_q); prev_d = mulp_q + 32'(idx_q);
          if (idx_q == AW'(N-1)) begin
            st_d = S_IDLE; pos_d = AW'(N);
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_take_o = 1'b1;
          left_d = req_i.draws; ismod_d = req_i.is_mod; bound_d = req_i.bound;
          second_d = 1'b0; val_d = '0;
          st_d = (req_i.draws == 2'd0) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        if (pos_q == AW'(N)) begin
          idx_d = '0; st_d = S_TW0;
        end else begin
          raddr = pos_q; st_d = S_RDW;
        end
      end
      // twist: read w[i] then w[i+1] then w[i+m], write w[i]
      S_TW0: begin raddr = idx_q; st_d = S_TW1; end
      S_TW1: begin raddr = wrap(idx_q, 1); st_d = S_TW2; end
      S_TW2: begin
        a_d = wi_q; b_d = rdata; raddr = wrap(idx_q, M); st_d = S_TW3;
      end
      S_TW3: begin st_d = S_TW0; end
      S_RDW: begin raddr = pos_q; st_d = S_RDD; end
      S_RDD: begin
        pos_d = pos_q + AW'(1);
        if (ismod_q) begin
          dstart = 1'b1; st_d = S_DIV;
        end else if (!second_q) begin
          lo_d = tw[30:0]; val_d = {31'd0, tw[30:0]};
          second_d = 1'b1;
          st_d = (left_q == 2'd2) ? S_RD : S_OUT;
        end else begin
          val_d = {tw[30:0], lo_q}; st_d = S_OUT;
        end
      end
      S_DIV: begin
        if (ddone) begin
          val_d = {30'd0, drem}; st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!stall_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // finishing a twist word: S_TW3 holds rdata of w[i+m]
    if (st_q == S_TW3) begin
      we = 1'b1; waddr = idx_q;
      wdata = rdata ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
      if (idx_q == AW'(N-1)) begin
        pos_d = '0; st_d = S_RD;
      end else begin
        idx_d = idx_q + AW'(1); st_d = S_TW0;
      end
    end
    if (pend_q && (st_q == S_IDLE)) begin
      st_d = S_SEED; req_take_o = 1'b0; left_d = left_q;
    end
  end

  // w[i] is on rdata during TW1, w[i+1] during TW2
  always_ff @(posedge clk_i) begin
    if (st_q == S_TW1) wi_q <= rdata;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; prev_q <= prev_d;
    a_q <= a_d;
    b_q <= b_d; bound_q <= bound_d; lo_q <= lo_d; val_q <= val_d;
    ismod_q <= ismod_d; second_q <= second_d; left_q <= left_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_SEED;
      pos_q  <= AW'(N);
      mul_q  <= 1'b0;
      pend_q <= 1'b0;
      seed_q <= SEED_RESET;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      mul_q <= mul_d;
      if (seed_we_i) seed_q <= seed_i;
      if (seed_we_i) pend_q <= 1'b1;
      else if (st_q == S_SEED) pend_q <= 1'b0;
    end
  end

  assign valid_o = st_q == S_OUT;
  assign value_o = val_q;
endmodule
